/* rtl/hnt_pkg.sv */
// Shared constants, types and helpers of the hash noise texel pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package hnt_pkg;

    localparam int COORD_W    = 10;
    localparam int HASH_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int COLOR_W    = 3 * FRAC_W;
    localparam int FINE_W     = 14;
    localparam int PIPE_DEPTH = 9;
    localparam int APB_DW     = 64;
    localparam int APB_AW     = 6;

    // Q0.16 unity, one bit wider than a fraction
    localparam logic [FRAC_W:0] ONE_Q16 = 17'h10000;

    // multiply-xorshift hash constants
    localparam logic [HASH_W-1:0] HASH_MUL_X = 32'd374761393;
    localparam logic [HASH_W-1:0] HASH_MUL_Y = 32'd668265263;
    localparam logic [HASH_W-1:0] HASH_MUL_S = 32'd2246822519;
    localparam logic [HASH_W-1:0] HASH_MUL_F = 32'd1274126177;

    // seed offsets of the pattern, mid-scale and grain hashes
    localparam logic [HASH_W-1:0] SEED_OFS_PAT  = 32'd17;
    localparam logic [HASH_W-1:0] SEED_OFS_MID  = 32'd23;
    localparam logic [HASH_W-1:0] SEED_OFS_FINE = 32'd31;

    // 0.58 and 0.42 as Q0.16
    localparam logic [FRAC_W-1:0] MIX_BROAD = 16'd38011;
    localparam logic [FRAC_W-1:0] MIX_MID   = 16'd27525;

    // ceil(2^16 / d): exact quotient for every 10-bit dividend
    localparam logic [15:0] RECIP_3  = 16'd21846;
    localparam logic [15:0] RECIP_7  = 16'd9363;
    localparam logic [15:0] RECIP_13 = 16'd5042;
    localparam logic [15:0] RECIP_19 = 16'd3450;

    typedef enum logic [2:0] {
        REG_BASE   = 3'd0,
        REG_ACCENT = 3'd1,
        REG_SEED   = 3'd2,
        REG_GRAIN  = 3'd3,
        REG_ISO    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic ld_prod;
        logic ld_mix;
        logic ld_scr;
    } t_hash_ctl;

    typedef struct packed {
        logic ld_mix;
        logic ld_out;
    } t_chan_ctl;

    // quotient by a small constant via reciprocal multiply
    function automatic logic [COORD_W-1:0] div_const(input logic [COORD_W-1:0] x,
                                                    input logic [15:0] recip);
        logic [COORD_W+15:0] prod;
        prod = {16'd0, x} * {{COORD_W{1'b0}}, recip};
        return prod[COORD_W+15:16];
    endfunction

endpackage

`default_nettype wire

/* rtl/hash_noise_texture_pixel.sv */
// Top level of the procedural value-noise texel generator: APB registers,
// nine-stage pipeline with per-stage valid bits. Uses hnt_pkg, hnt_hash, hnt_chan.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------------
//  pixel     in         i_in_valid / o_in_ready   i_pixel_x, i_pixel_y
//  texel     out        o_out_valid / i_out_ready o_red, o_green, o_blue, o_alpha
//  config    in         APB psel/penable/pready   paddr, pwdata, prdata
//
// One texel per cycle sustained while i_out_ready holds high; o_out_valid rises once a texel reaches the last stage.
// Depth is set by the hash chain (product, mix and scramble stages) and the pattern/blend
// multiplies.
// Each stage loads when empty or when the stage after it moves, so bubbles collapse
// and a full pipeline stalls from the output back to o_in_ready.
// Synchronous active-low reset clears registers and valid bits; data needs no reset.
`default_nettype none

module hash_noise_texture_pixel import hnt_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [COORD_W-1:0]   i_pixel_x,
    input  wire logic [COORD_W-1:0]   i_pixel_y,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [7:0]           o_red,
    output logic      [7:0]           o_green,
    output logic      [7:0]           o_blue,
    output logic      [7:0]           o_alpha,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic      [APB_DW-1:0]    prdata,
    output logic                      pready
);

    // ---------------- configuration registers ----------------
    logic [COLOR_W-1:0] r_base, r_accent;
    logic [HASH_W-1:0]  r_seed;
    logic [FRAC_W-1:0]  r_grain;
    logic               r_iso;
    logic               w_wr;
    t_reg_idx           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_accent <= '0;
            r_seed   <= '0;
            r_grain  <= '0;
            r_iso    <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_BASE:   r_base   <= pwdata[COLOR_W-1:0];
                REG_ACCENT: r_accent <= pwdata[COLOR_W-1:0];
                REG_SEED:   r_seed   <= pwdata[HASH_W-1:0];
                REG_GRAIN:  r_grain  <= pwdata[FRAC_W-1:0];
                REG_ISO:    r_iso    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_BASE:   prdata = {{(APB_DW-COLOR_W){1'b0}}, r_base};
            REG_ACCENT: prdata = {{(APB_DW-COLOR_W){1'b0}}, r_accent};
            REG_SEED:   prdata = {{(APB_DW-HASH_W){1'b0}}, r_seed};
            REG_GRAIN:  prdata = {{(APB_DW-FRAC_W){1'b0}}, r_grain};
            REG_ISO:    prdata = {{(APB_DW-1){1'b0}}, r_iso};
            default:    prdata = '0;
        endcase
    end

    // ---------------- valid chain ----------------
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH:0]   w_ld;

    always_comb begin
        w_ld[PIPE_DEPTH] = i_out_ready;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_ld[0];
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    // ---------------- stage 0: block coordinates ----------------
    logic [COORD_W-1:0] r0_q3x, r0_q3y, r0_qpx, r0_qpy, r0_q7x, r0_q7y, r0_px, r0_py;

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r0_q3x <= div_const(i_pixel_x, RECIP_3);
            r0_q3y <= div_const(i_pixel_y, RECIP_3);
            r0_q7x <= div_const(i_pixel_x, RECIP_7);
            r0_q7y <= div_const(i_pixel_y, RECIP_7);
            // pattern block: 13x13 square or 19x7 stretch
            r0_qpx <= r_iso ? div_const(i_pixel_x, RECIP_13) : div_const(i_pixel_x, RECIP_19);
            r0_qpy <= r_iso ? div_const(i_pixel_y, RECIP_13) : div_const(i_pixel_y, RECIP_7);
            r0_px  <= i_pixel_x;
            r0_py  <= i_pixel_y;
        end
    end

    // ---------------- stages 1..3: hashes ----------------
    t_hash_ctl          w_hctl;
    logic [HASH_W-1:0]  w_h_noise, w_h_pat, w_h_mid, w_h_fine;

    assign w_hctl = '{ld_prod: w_ld[1], ld_mix: w_ld[2], ld_scr: w_ld[3]};

    hnt_hash u_hash_noise (
        .i_clk (i_clk), .i_ctl (w_hctl), .i_cx (r0_q3x), .i_cy (r0_q3y),
        .i_seed (r_seed), .o_hash (w_h_noise)
    );

    hnt_hash u_hash_pat (
        .i_clk (i_clk), .i_ctl (w_hctl), .i_cx (r0_qpx), .i_cy (r0_qpy),
        .i_seed (r_seed + SEED_OFS_PAT), .o_hash (w_h_pat)
    );

    hnt_hash u_hash_mid (
        .i_clk (i_clk), .i_ctl (w_hctl), .i_cx (r0_q7x), .i_cy (r0_q7y),
        .i_seed (r_seed + SEED_OFS_MID), .o_hash (w_h_mid)
    );

    hnt_hash u_hash_fine (
        .i_clk (i_clk), .i_ctl (w_hctl), .i_cx (r0_px), .i_cy (r0_py),
        .i_seed (r_seed + SEED_OFS_FINE), .o_hash (w_h_fine)
    );

    // ---------------- stage 4: levels ----------------
    logic [FRAC_W-1:0]  w_noise, w_pat, w_mid;
    logic [31:0]        n4_ng_prod, n4_x;
    logic [31:0]        r4_x;
    logic [FRAC_W-1:0]  r4_ng;
    logic [FINE_W-1:0]  r4_fine;

    always_comb begin
        // byte fraction h/255 as h*257
        w_noise    = {w_h_noise[7:0], w_h_noise[7:0]};
        w_pat      = {w_h_pat[7:0], w_h_pat[7:0]};
        w_mid      = {w_h_mid[7:0], w_h_mid[7:0]};
        n4_ng_prod = {16'd0, w_noise} * {16'd0, r_grain};
        // pattern weight before the (1 - g) scale, kept as a 2^-32 fraction
        n4_x = r_iso ? ({16'd0, w_pat} * {16'd0, MIX_BROAD} + {16'd0, w_mid} * {16'd0, MIX_MID})
                     : {w_pat, 16'd0};
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[4]) begin
            r4_x    <= n4_x;
            r4_ng   <= n4_ng_prod[31:16];
            r4_fine <= {w_h_fine[5:0], 2'b00, w_h_fine[5:0]};
        end
    end

    // ---------------- stage 5: pattern ----------------
    logic [FRAC_W:0]    w_rem;
    logic [48:0]        n5_prod;
    logic [FRAC_W-1:0]  r5_pat, r5_ng;
    logic [FINE_W-1:0]  r5_fine;

    always_comb begin
        w_rem   = ONE_Q16 - {1'b0, r_grain};
        n5_prod = {17'd0, r4_x} * {32'd0, w_rem};
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[5]) begin
            r5_pat  <= n5_prod[47:32];
            r5_ng   <= r4_ng;
            r5_fine <= r4_fine;
        end
    end

    // ---------------- stage 6: blend factor ----------------
    logic [FRAC_W:0]    n6_sum, n6_t;
    logic [FRAC_W:0]    r6_t, r6_tinv;
    logic [FINE_W-1:0]  r6_fine;

    always_comb begin
        n6_sum = {1'b0, r5_ng} + {1'b0, r5_pat};
        n6_t   = (n6_sum > ONE_Q16) ? ONE_Q16 : n6_sum;
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[6]) begin
            r6_t    <= n6_t;
            r6_tinv <= ONE_Q16 - n6_t;
            r6_fine <= r5_fine;
        end
    end

    // ---------------- stages 7..8: channels ----------------
    t_chan_ctl w_cctl;

    assign w_cctl = '{ld_mix: w_ld[7], ld_out: w_ld[8]};

    hnt_chan u_chan_red (
        .i_clk (i_clk), .i_ctl (w_cctl),
        .i_base (r_base[47:32]), .i_accent (r_accent[47:32]),
        .i_t (r6_t), .i_tinv (r6_tinv), .i_fine (r6_fine), .o_byte (o_red)
    );

    hnt_chan u_chan_green (
        .i_clk (i_clk), .i_ctl (w_cctl),
        .i_base (r_base[31:16]), .i_accent (r_accent[31:16]),
        .i_t (r6_t), .i_tinv (r6_tinv), .i_fine (r6_fine), .o_byte (o_green)
    );

    hnt_chan u_chan_blue (
        .i_clk (i_clk), .i_ctl (w_cctl),
        .i_base (r_base[15:0]), .i_accent (r_accent[15:0]),
        .i_t (r6_t), .i_tinv (r6_tinv), .i_fine (r6_fine), .o_byte (o_blue)
    );

    assign o_alpha = 8'hFF;

`ifndef SYNTHESIS
    // backpressure reaches the input only when every stage is occupied
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld))
        else $error("input stalled with a free pipeline stage");

    // an accepted transaction always lands in the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted transaction lost at pipeline entry");

    // blend factor and its complement sum to one
    a_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] |-> ((r6_t + r6_tinv) == ONE_Q16))
        else $error("blend factor pair out of step");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_vld == '0))
        else $error("valid bits survive reset");
`endif

endmodule

`default_nettype wire

/* rtl/hnt_hash.sv */
// Three-stage 32-bit multiply-xorshift coordinate hash.
// Depends on hnt_pkg; stage loads come from the parent's valid chain.
`default_nettype none

module hnt_hash import hnt_pkg::*; (
    input  wire logic                  i_clk,
    input  wire t_hash_ctl             i_ctl,
    input  wire logic [COORD_W-1:0]    i_cx,
    input  wire logic [COORD_W-1:0]    i_cy,
    input  wire logic [HASH_W-1:0]     i_seed,
    output logic      [HASH_W-1:0]     o_hash
);

    logic [HASH_W-1:0] r_px, r_py, r_ps;
    logic [HASH_W-1:0] n_px, n_py, n_ps;
    logic [HASH_W-1:0] r_mix, n_mix, n_sum;
    logic [HASH_W-1:0] r_scr, n_scr;

    always_comb begin
        n_px  = {{(HASH_W-COORD_W){1'b0}}, i_cx} * HASH_MUL_X;
        n_py  = {{(HASH_W-COORD_W){1'b0}}, i_cy} * HASH_MUL_Y;
        n_ps  = i_seed * HASH_MUL_S;
        n_sum = r_px + r_py + r_ps;
        n_mix = n_sum ^ (n_sum >> 13);
        n_scr = r_mix * HASH_MUL_F;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_prod) begin
            r_px <= n_px;
            r_py <= n_py;
            r_ps <= n_ps;
        end
        if (i_ctl.ld_mix) begin
            r_mix <= n_mix;
        end
        if (i_ctl.ld_scr) begin
            r_scr <= n_scr;
        end
    end

    assign o_hash = r_scr ^ (r_scr >> 16);

endmodule

`default_nettype wire

/* rtl/hnt_chan.sv */
// One colour channel: base/accent blend, grain add, saturation and byte scaling.
// Depends on hnt_pkg; two register stages loaded by the parent's valid chain.
`default_nettype none

module hnt_chan import hnt_pkg::*; (
    input  wire logic                i_clk,
    input  wire t_chan_ctl           i_ctl,
    input  wire logic [FRAC_W-1:0]   i_base,
    input  wire logic [FRAC_W-1:0]   i_accent,
    input  wire logic [FRAC_W:0]     i_t,
    input  wire logic [FRAC_W:0]     i_tinv,
    input  wire logic [FINE_W-1:0]   i_fine,
    output logic      [7:0]          o_byte
);

    logic [32:0]        n_prod;
    logic [FRAC_W-1:0]  r_mix;
    logic [FINE_W-1:0]  r_fine;
    logic [FRAC_W:0]    n_sum, n_sat;
    logic [FRAC_W+8:0]  n_scaled;
    logic [7:0]         r_byte;

    always_comb begin
        n_prod   = {17'd0, i_base} * {16'd0, i_tinv} + {17'd0, i_accent} * {16'd0, i_t};
        n_sum    = {1'b0, r_mix} + {3'd0, r_fine};
        n_sat    = (n_sum > ONE_Q16) ? ONE_Q16 : n_sum;
        // v * 255 as a shift and subtract
        n_scaled = {n_sat, 8'd0} - {8'd0, n_sat};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mix) begin
            r_mix  <= n_prod[31:16];
            r_fine <= i_fine;
        end
        if (i_ctl.ld_out) begin
            r_byte <= n_scaled[23:16];
        end
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for hash_noise_texture_pixel: random and directed pixels in both
// pattern modes, texels predicted in the bench and compared per channel. Needs hnt_pkg.

module tb_top;
    import hnt_pkg::*;

    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          PHASE_PIXELS = 190;
    localparam logic [2:0]  REG_SPARE_LO = 3'd5;
    localparam logic [2:0]  REG_SPARE_HI = 3'd7;
    localparam logic [47:0] WHITE_RGB    = 48'hFFFF_FFFF_FFFF;

    // Expected texels and the bench's copy of the texel arithmetic and registers.
    class texel_book;
        typedef struct packed {
            logic [7:0] red;
            logic [7:0] green;
            logic [7:0] blue;
            logic [7:0] alpha;
        } texel_t;

        localparam logic [63:0] Q16_ONE      = 64'd65536;
        localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

        texel_t      pending[$];
        logic [47:0] base_rgb;
        logic [47:0] accent_rgb;
        logic [31:0] seed;
        logic [15:0] grain;
        logic        iso;
        int unsigned faults;

        function new();
            base_rgb   = '0;
            accent_rgb = '0;
            seed       = '0;
            grain      = '0;
            iso        = 1'b0;
            faults     = 0;
        endfunction

        // drop bits above each register's width; unknown indexes change nothing
        function void set_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                REG_BASE:   base_rgb   = val[47:0];
                REG_ACCENT: accent_rgb = val[47:0];
                REG_SEED:   seed       = val[31:0];
                REG_GRAIN:  grain      = val[15:0];
                REG_ISO:    iso        = val[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] coord_hash(logic [31:0] cx, logic [31:0] cy, logic [31:0] s);
            logic [31:0] v;
            v = cx * 32'd374761393 + cy * 32'd668265263 + s * 32'd2246822519;
            v = (v ^ (v >> 13)) * 32'd1274126177;
            return v ^ (v >> 16);
        endfunction

        // hashed byte as a Q0.16 fraction
        function logic [63:0] level(logic [31:0] h);
            return {56'd0, h[7:0]} * 64'd257;
        endfunction

        function texel_t shade(logic [9:0] x, logic [9:0] y);
            logic [31:0] px;
            logic [31:0] py;
            logic [63:0] g64;
            logic [63:0] rem;
            logic [63:0] noise;
            logic [63:0] pat;
            logic [63:0] t;
            logic [63:0] fine;
            logic [63:0] lb;
            logic [63:0] la;
            logic [63:0] v;
            logic [7:0]  chan[3];
            texel_t      res;
            px    = {22'd0, x};
            py    = {22'd0, y};
            g64   = {48'd0, grain};
            rem   = Q16_ONE - g64;
            noise = level(coord_hash(px / 32'd3, py / 32'd3, seed));
            if (iso) begin
                pat = (level(coord_hash(px / 32'd13, py / 32'd13, seed + 32'd17))
                          * rem * 64'd38011
                     + level(coord_hash(px / 32'd7, py / 32'd7, seed + 32'd23))
                          * rem * 64'd27525) >> 32;
            end else begin
                pat = (level(coord_hash(px / 32'd19, py / 32'd7, seed + 32'd17)) * rem) >> 16;
            end
            t = ((noise * g64) >> 16) + pat;
            if (t > Q16_ONE) begin
                t = Q16_ONE;
            end
            fine = {32'd0, coord_hash(px, py, seed + 32'd31) & 32'd63} * 64'd257;
            for (int k = 0; k < 3; k++) begin
                lb = {48'd0, base_rgb[47 - 16 * k -: 16]};
                la = {48'd0, accent_rgb[47 - 16 * k -: 16]};
                v  = ((lb * (Q16_ONE - t) + la * t) >> 16) + fine;
                if (v > Q16_ONE) begin
                    v = Q16_ONE;
                end
                v       = (v * 64'd255) >> 16;
                chan[k] = v[7:0];
            end
            res.red   = chan[0];
            res.green = chan[1];
            res.blue  = chan[2];
            res.alpha = ALPHA_OPAQUE;
            return res;
        endfunction

        function void note_pixel(logic [9:0] x, logic [9:0] y);
            pending.insert(pending.size(), shade(x, y));
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                faults++;
            end
        endfunction

        function void check_texel(texel_t got);
            texel_t want;
            if (pending.size() == 0) begin
                $error("texel with no pixel pending: %h", got);
                faults++;
                return;
            end
            want = pending.pop_front();
            compare("red", want.red, got.red);
            compare("green", want.green, got.green);
            compare("blue", want.blue, got.blue);
            compare("alpha", want.alpha, got.alpha);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [COORD_W-1:0]  i_pixel_x;
    logic [COORD_W-1:0]  i_pixel_y;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [7:0]          o_red;
    logic [7:0]          o_green;
    logic [7:0]          o_blue;
    logic [7:0]          o_alpha;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    texel_book book = new();
    int        cycles       = 0;
    int        stall_left   = 0;
    int        in_idle_pct  = 30;
    int        out_idle_pct = 30;
    bit        calm         = 1'b0;

    hash_noise_texture_pixel DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_alpha     (o_alpha),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("hash_noise_texture_pixel: mismatch");
            $finish;
        end
    end

    // texel side: check each transaction, then decide whether to stall
    always @(posedge i_clk) begin
        texel_book::texel_t got;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = {o_red, o_green, o_blue, o_alpha};
                book.check_texel(got);
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
                stall_left = $urandom_range(1, 9);
            end
            i_out_ready <= (stall_left == 0);
        end
    end

    task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
        int gap;
        if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_x  <= x;
        i_pixel_y  <= y;
        do @(posedge i_clk); while (!o_in_ready);
        book.note_pixel(x, y);
    endtask

    // hold the sender until every texel is back, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        book.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // junk above each register's width must be ignored
    task automatic program_regs(input logic [47:0] base, input logic [47:0] accent,
                                input logic [31:0] seed, input logic [15:0] grain,
                                input logic iso);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        apb_write(REG_BASE, {junk[63:48], base});
        apb_write(REG_ACCENT, {junk[15:0], accent});
        apb_write(REG_SEED, {junk[31:0], seed});
        apb_write(REG_GRAIN, {junk[63:16], grain});
        apb_write(REG_ISO, {junk[63:1], iso});
        apb_write(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), {$urandom, $urandom});
    endtask

    function automatic logic [47:0] rand_colour();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    initial begin
        logic [9:0]  dir_x[11];
        logic [9:0]  dir_y[11];
        logic [47:0] base;
        logic [47:0] accent;
        logic [31:0] seed;
        logic [15:0] grain;
        logic        iso;
        logic [19:0] raster;

        dir_x = '{0, 1023, 0, 1023, 2, 6, 12, 18, 19, 13, 682};
        dir_y = '{0, 1023, 1023, 0, 3, 7, 13, 19, 7, 20, 341};

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_pixel_x   <= '0;
        i_pixel_y   <= '0;
        i_out_ready <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset: texel is grain alone
        for (int i = 0; i < 3; i++) begin
            send_pixel(dir_x[i], dir_y[i]);
        end
        drain();
        // stretched blocks, black to white, no noise weight
        program_regs(48'd0, WHITE_RGB, 32'd0, 16'd0, 1'b0);
        for (int i = 0; i < 11; i++) begin
            send_pixel(dir_x[i], dir_y[i]);
        end
        drain();
        // square blocks, full noise weight, seed wraps, grain saturates white
        program_regs(WHITE_RGB, 48'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        for (int i = 0; i < 11; i++) begin
            send_pixel(dir_x[10 - i], dir_y[10 - i]);
        end

        raster = 20'($urandom);
        for (int ph = 0; ph < 7; ph++) begin
            base   = rand_colour();
            accent = rand_colour();
            seed   = $urandom;
            grain  = 16'($urandom);
            iso    = 1'($urandom);
            in_idle_pct  = 30;
            out_idle_pct = 30;
            case (ph)
                0: iso = 1'b0;
                1: begin
                    iso = 1'b1;
                    grain = 16'hFFFF;
                    in_idle_pct  = 50;
                    out_idle_pct = 10;
                end
                2: begin
                    iso = 1'b0;
                    grain = 16'd0;
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
                3: begin
                    iso = 1'b1;
                    grain = 16'd0;
                    seed = 32'hFFFF_FFFF;
                    base = WHITE_RGB;
                    accent = WHITE_RGB;
                    in_idle_pct  = 20;
                    out_idle_pct = 50;
                end
                5: iso = 1'b1;
                6: calm = 1'b1;
                default: ;
            endcase
            drain();
            program_regs(base, accent, seed, grain, iso);
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                if (ph == 5 && n == PHASE_PIXELS / 2) begin
                    drain();
                end
                // half raster runs for neighbouring blocks, half scattered
                if ($urandom_range(0, 1)) begin
                    raster = 20'($urandom);
                end else begin
                    raster = raster + 20'd1;
                end
                send_pixel(raster[9:0], raster[19:10]);
            end
        end

        drain();
        if (book.faults == 0) begin
            $display("hash_noise_texture_pixel: match");
        end else begin
            $display("hash_noise_texture_pixel: mismatch");
        end
        $finish;
    end

endmodule
